// ===== hw/rtl/srmd_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// srmd_pkg
// Types and constants shared by the stereo ROI minimum depth block.
// ============================================================================
package srmd_pkg;

    localparam int DISP_W  = 13;
    localparam int DIV_W   = 12;
    localparam int GEO_W   = 12;
    localparam int SHIFT_W = 3;
    localparam int CFG_W   = 20;
    localparam int CIDX_W  = 3;
    localparam int QUO_W   = CFG_W + 4;
    localparam int STEP_W  = 5;

    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    localparam logic [CIDX_W-1:0] REG_FRAME_WIDTH     = 3'd0;
    localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT    = 3'd1;
    localparam logic [CIDX_W-1:0] REG_ROI_SHIFT       = 3'd2;
    localparam logic [CIDX_W-1:0] REG_FOCAL_BASELINE  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_MIN_VALID_DEPTH = 3'd4;
    localparam logic [CIDX_W-1:0] REG_NO_TARGET_DEPTH = 3'd5;

    localparam logic [GEO_W-1:0]   RST_FRAME_WIDTH     = 12'd1640;
    localparam logic [GEO_W-1:0]   RST_FRAME_HEIGHT    = 12'd1232;
    localparam logic [SHIFT_W-1:0] RST_ROI_SHIFT       = 3'd2;
    localparam logic [CFG_W-1:0]   RST_FOCAL_BASELINE  = 20'd42000;
    localparam logic [CFG_W-1:0]   RST_MIN_VALID_DEPTH = 20'd50;
    localparam logic [CFG_W-1:0]   RST_NO_TARGET_DEPTH = 20'd99000;

    localparam logic [DIV_W-1:0] MIN_DISPARITY = 12'd16;

    typedef struct packed {
        logic [GEO_W-1:0]   frame_width;
        logic [GEO_W-1:0]   frame_height;
        logic [SHIFT_W-1:0] roi_shift;
        logic [CFG_W-1:0]   focal_baseline;
        logic [CFG_W-1:0]   min_valid_depth;
        logic [CFG_W-1:0]   no_target_depth;
    } cfg_t;

    typedef struct packed {
        logic             sof;
        logic             frame_end;
        logic             in_center;
        logic             in_left;
        logic             in_right;
        logic             usable;
        logic [DIV_W-1:0] divisor;
    } cmd_t;

    typedef struct packed {
        logic [CFG_W-1:0] center;
        logic [CFG_W-1:0] left;
        logic [CFG_W-1:0] right;
    } res_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_APPLY,
        BK_EMIT
    } back_state_t;

endpackage

// ===== hw/rtl/srmd_fifo.sv =====
`timescale 1ns / 1ps
// ============================================================================
// srmd_fifo
// Small show-ahead queue in flip-flops; the head entry is always on rd_data.
// ============================================================================
module srmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/srmd_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// srmd_front
// Raster position tracking and ROI classification of each incoming pixel.
// ============================================================================
module srmd_front
    import srmd_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic signed [DISP_W-1:0] disparity_q4,
    input  logic                     start_of_frame,
    input  logic                     push,
    output logic                     full,
    output logic                     cmd_push,
    output cmd_t                     cmd_data,
    input  logic                     cmd_full
);

    localparam int XW = ((COORD_BITS > GEO_W) ? COORD_BITS : GEO_W) + 1;

    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [COORD_BITS-1:0] col_now, row_now;
    logic [GEO_W-1:0]      roi_w, roi_h, roi_x, roi_y, half;
    logic [XW-1:0]         col_x, row_x, w_x, h_x;
    logic [XW-1:0]         x_lo, x_end, x_mid, x_rend, y_lo, y_end;
    logic                  row_ok, row_end, frame_end, accept;

    assign full     = cmd_full;
    assign accept   = push && !cmd_full;
    assign cmd_push = accept;

    always_comb
    begin
        col_now = start_of_frame ? '0 : col_reg;
        row_now = start_of_frame ? '0 : row_reg;
        col_x   = XW'(col_now);
        row_x   = XW'(row_now);
        w_x     = XW'(cfg.frame_width);
        h_x     = XW'(cfg.frame_height);

        roi_w = cfg.frame_width >> cfg.roi_shift;
        roi_h = cfg.frame_height >> cfg.roi_shift;
        roi_x = (cfg.frame_width - roi_w) >> 1;
        roi_y = (cfg.frame_height - roi_h) >> 1;
        half  = roi_w >> 1;

        x_lo   = XW'(roi_x);
        x_end  = x_lo + XW'(roi_w);
        x_mid  = x_lo + XW'(half);
        x_rend = x_mid + XW'(half);
        y_lo   = XW'(roi_y);
        y_end  = y_lo + XW'(roi_h);

        row_ok    = (row_x >= y_lo) && (row_x < y_end);
        row_end   = (col_x + XW'(1)) >= w_x;
        frame_end = row_end && ((row_x + XW'(1)) >= h_x);

        if (!row_end)
        begin
            col_next = col_now + COORD_BITS'(1);
            row_next = row_now;
        end
        else
        begin
            col_next = '0;
            row_next = frame_end ? '0 : row_now + COORD_BITS'(1);
        end

        cmd_data.sof       = start_of_frame;
        cmd_data.frame_end = frame_end;
        cmd_data.in_center = row_ok && (col_x >= x_lo) && (col_x < x_end);
        cmd_data.in_left   = row_ok && (col_x >= x_lo) && (col_x < x_mid);
        cmd_data.in_right  = row_ok && (col_x >= x_mid) && (col_x < x_rend);
        cmd_data.usable    = !disparity_q4[DISP_W-1]
                             && (disparity_q4[DIV_W-1:0] > MIN_DISPARITY);
        cmd_data.divisor   = disparity_q4[DIV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== hw/rtl/srmd_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// srmd_back
// Depth division, region minimum tracking and end-of-frame result request.
// ============================================================================
module srmd_back
    import srmd_pkg::*;
#(
    parameter int DEPTH_BITS = 20
) (
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  cmd_t cmd_data,
    input  logic cmd_empty,
    output logic cmd_pop,
    input  logic res_full,
    output logic res_push,
    output res_t res_data
);

    localparam int CMP_W = (DEPTH_BITS > CFG_W) ? DEPTH_BITS : CFG_W;

    back_state_t           state_reg, state_next;
    cmd_t                  cmd_reg;
    logic [QUO_W-1:0]      num_reg, num_next;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [STEP_W-1:0]     step_reg;
    logic [DEPTH_BITS-1:0] center_min_reg, left_min_reg, right_min_reg;
    logic [2:0]            ok_reg;

    logic                  load, div_run, apply_en, clear_min;
    logic [DIV_W:0]        rem_sh;
    logic                  ge;
    logic [DEPTH_BITS-1:0] depth;
    logic                  depth_ok;
    logic [CMP_W-1:0]      c_ext, l_ext, r_ext;

    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[QUO_W-1]};
        ge       = rem_sh >= {1'b0, cmd_reg.divisor};
        rem_next = ge ? DIV_W'(rem_sh - {1'b0, cmd_reg.divisor}) : rem_sh[DIV_W-1:0];
        num_next = {num_reg[QUO_W-2:0], ge};

        if ((num_reg >> DEPTH_BITS) != '0)
        begin
            depth = '1;
        end
        else
        begin
            depth = num_reg[DEPTH_BITS-1:0];
        end
        depth_ok = CMP_W'(depth) > CMP_W'(cfg.min_valid_depth);

        c_ext = CMP_W'(center_min_reg);
        l_ext = CMP_W'(left_min_reg);
        r_ext = CMP_W'(right_min_reg);
        res_data.center = ok_reg[2] ? c_ext[CFG_W-1:0] : cfg.no_target_depth;
        res_data.left   = ok_reg[1] ? l_ext[CFG_W-1:0] : cfg.no_target_depth;
        res_data.right  = ok_reg[0] ? r_ext[CFG_W-1:0] : cfg.no_target_depth;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    if (cmd_data.usable
                        && (cmd_data.in_center || cmd_data.in_left || cmd_data.in_right))
                    begin
                        state_next = BK_DIV;
                    end
                    else if (cmd_data.frame_end)
                    begin
                        state_next = BK_EMIT;
                    end
                end
            end
            BK_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = BK_APPLY;
                end
            end
            BK_APPLY:
            begin
                state_next = cmd_reg.frame_end ? BK_EMIT : BK_IDLE;
            end
            BK_EMIT:
            begin
                if (!res_full)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop   = 1'b0;
        load      = 1'b0;
        div_run   = 1'b0;
        apply_en  = 1'b0;
        res_push  = 1'b0;
        clear_min = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                cmd_pop   = !cmd_empty;
                load      = !cmd_empty;
                clear_min = !cmd_empty && cmd_data.sof;
            end
            BK_DIV:
            begin
                div_run = 1'b1;
            end
            BK_APPLY:
            begin
                apply_en = 1'b1;
            end
            BK_EMIT:
            begin
                res_push  = !res_full;
                clear_min = !res_full;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            ok_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clear_min)
            begin
                ok_reg <= '0;
            end
            else if (apply_en && depth_ok)
            begin
                if (cmd_reg.in_center && (!ok_reg[2] || depth < center_min_reg))
                begin
                    ok_reg[2] <= 1'b1;
                end
                if (cmd_reg.in_left && (!ok_reg[1] || depth < left_min_reg))
                begin
                    ok_reg[1] <= 1'b1;
                end
                if (cmd_reg.in_right && (!ok_reg[0] || depth < right_min_reg))
                begin
                    ok_reg[0] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg  <= cmd_data;
            num_reg  <= {cfg.focal_baseline, 4'b0000};
            rem_reg  <= '0;
            step_reg <= STEP_W'(QUO_W - 1);
        end
        else if (div_run)
        begin
            num_reg  <= num_next;
            rem_reg  <= rem_next;
            step_reg <= step_reg - STEP_W'(1);
        end
        if (apply_en && depth_ok)
        begin
            if (cmd_reg.in_center && (!ok_reg[2] || depth < center_min_reg))
            begin
                center_min_reg <= depth;
            end
            if (cmd_reg.in_left && (!ok_reg[1] || depth < left_min_reg))
            begin
                left_min_reg <= depth;
            end
            if (cmd_reg.in_right && (!ok_reg[0] || depth < right_min_reg))
            begin
                right_min_reg <= depth;
            end
        end
    end

endmodule

// ===== hw/rtl/stereo_roi_min_depth.sv =====
`timescale 1ns / 1ps
// ============================================================================
// stereo_roi_min_depth
// Minimum depth over a centered region of interest of a disparity frame.
// ============================================================================
// Pixels enter in raster order on the push/full side, one request per pixel,
// with start_of_frame marking the first pixel of a frame. The front end
// tracks column and row and classifies each pixel against the ROI and its
// halves; it takes one pixel per cycle while its four-entry command queue has
// room. The back end takes queued pixels one at a time: one outside the ROI or
// with an unusable disparity is popped and skipped; one in the ROI with a
// usable disparity goes through the one-bit-per-cycle restoring divider that
// forms focal_baseline*16/disparity_q4, then updates the minima. After the
// last pixel of a frame the back end puts the center, left and right minima
// into a two-entry result queue, read on the empty/pop side. When the result
// queue is full the back end waits, the command queue fills and full rises,
// so nothing is dropped. Reset clears position, minima and both queues and
// loads the default configuration. The user must write registers through
// cfg_we/cfg_index/cfg_data only while the block is idle; nothing enforces it.
// ============================================================================
module stereo_roi_min_depth
    import srmd_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 20
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CIDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic signed [DISP_W-1:0] disparity_q4,
    input  logic                     start_of_frame,
    input  logic                     push,
    output logic                     full,
    output logic [CFG_W-1:0]         center_depth,
    output logic [CFG_W-1:0]         left_depth,
    output logic [CFG_W-1:0]         right_depth,
    output logic                     empty,
    input  logic                     pop
);

    cfg_t cfg_reg;
    cmd_t cmd_in, cmd_out;
    res_t res_in, res_out;
    logic cmd_push, cmd_full, cmd_pop, cmd_empty;
    logic res_push, res_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width     <= RST_FRAME_WIDTH;
            cfg_reg.frame_height    <= RST_FRAME_HEIGHT;
            cfg_reg.roi_shift       <= RST_ROI_SHIFT;
            cfg_reg.focal_baseline  <= RST_FOCAL_BASELINE;
            cfg_reg.min_valid_depth <= RST_MIN_VALID_DEPTH;
            cfg_reg.no_target_depth <= RST_NO_TARGET_DEPTH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:     cfg_reg.frame_width     <= cfg_data[GEO_W-1:0];
                REG_FRAME_HEIGHT:    cfg_reg.frame_height    <= cfg_data[GEO_W-1:0];
                REG_ROI_SHIFT:       cfg_reg.roi_shift       <= cfg_data[SHIFT_W-1:0];
                REG_FOCAL_BASELINE:  cfg_reg.focal_baseline  <= cfg_data;
                REG_MIN_VALID_DEPTH: cfg_reg.min_valid_depth <= cfg_data;
                REG_NO_TARGET_DEPTH: cfg_reg.no_target_depth <= cfg_data;
                default:             cfg_reg.roi_shift       <= cfg_reg.roi_shift;
            endcase
        end
    end

    srmd_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .disparity_q4  (disparity_q4),
        .start_of_frame(start_of_frame),
        .push          (push),
        .full          (full),
        .cmd_push      (cmd_push),
        .cmd_data      (cmd_in),
        .cmd_full      (cmd_full)
    );

    srmd_fifo #(
        .WIDTH($bits(cmd_t)),
        .DEPTH(CMD_DEPTH)
    ) u_cmd_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_data(cmd_in),
        .full   (cmd_full),
        .rd_en  (cmd_pop),
        .rd_data(cmd_out),
        .empty  (cmd_empty)
    );

    srmd_back #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd_data (cmd_out),
        .cmd_empty(cmd_empty),
        .cmd_pop  (cmd_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_data (res_in)
    );

    srmd_fifo #(
        .WIDTH($bits(res_t)),
        .DEPTH(RES_DEPTH)
    ) u_res_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (res_push),
        .wr_data(res_in),
        .full   (res_full),
        .rd_en  (pop),
        .rd_data(res_out),
        .empty  (empty)
    );

    assign center_depth = res_out.center;
    assign left_depth   = res_out.left;
    assign right_depth  = res_out.right;

endmodule
